@@ hw/rtl/qps_pkg.sv @@
// ----------------------------------------------------------------------------
// qps_pkg
// Shared widths, codes and types of the quadrature position sampler.
// ----------------------------------------------------------------------------
package qps_pkg;

  // Sizes
  localparam int FIFO_DEPTH  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int TICK_W      = 16;
  localparam int ADDR_W      = $clog2(FIFO_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int FILL_W      = 5;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 1'd1;

  // Register reset values
  localparam logic [TICK_W-1:0]      TOP_RESET   = 16'd9999;
  localparam logic [COUNT_WIDTH-1:0] START_RESET = 16'd32768;

  // Sample store write and read request
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } ram_req_t;

  // Result fields known at accept time (sample value follows from the store)
  typedef struct packed {
    logic                   sample_valid;
    logic [FILL_W-1:0]      fifo_fill;
    logic                   sample_dropped;
    logic [COUNT_WIDTH-1:0] current_position;
  } result_t;

endpackage

@@ hw/rtl/qps_if.sv @@
// ----------------------------------------------------------------------------
// qps_cmd_if / qps_result_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface qps_cmd_if;
  import qps_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              level_a;
  logic              level_b;

  modport source (output valid, output mode, output level_a, output level_b, input ready);
  modport sink   (input valid, input mode, input level_a, input level_b, output ready);
endinterface

interface qps_result_if;
  import qps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] sample_value;
  logic                   sample_valid;
  logic [FILL_W-1:0]      fifo_fill;
  logic                   sample_dropped;
  logic [COUNT_WIDTH-1:0] current_position;

  modport source (output valid, output sample_value, output sample_valid, output fifo_fill,
                  output sample_dropped, output current_position, input ready);
  modport sink   (input valid, input sample_value, input sample_valid, input fifo_fill,
                  input sample_dropped, input current_position, output ready);
endinterface

@@ hw/rtl/qps_sample_ram.sv @@
// ----------------------------------------------------------------------------
// qps_sample_ram
// Snapshot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qps_sample_ram
  import qps_pkg::*;
(
  input  logic                   clk,
  input  ram_req_t               req,
  output logic [COUNT_WIDTH-1:0] rdata
);

  logic [COUNT_WIDTH-1:0] mem [FIFO_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hw/rtl/qps_core.sv @@
// ----------------------------------------------------------------------------
// qps_core
// Position counter, tick timer, FIFO pointers and configuration registers.
// Issues the store write (snapshot) or read (pop) for each accepted item.
// ----------------------------------------------------------------------------
module qps_core
  import qps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [MODE_W-1:0]     mode,
  input  logic                  level_a,
  input  logic                  level_b,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ram_req_t              ram_req,
  output result_t               res
);

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(FIFO_DEPTH);

  logic [COUNT_WIDTH-1:0] position, position_next;
  logic [TICK_W-1:0]      tick, tick_next;
  logic [PTR_W-1:0]       wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]       rd_ptr, rd_ptr_next;
  logic [TICK_W-1:0]      sample_top;
  logic [PTR_W-1:0]       fill, fill_next;
  logic                   dropped;
  logic                   popped;
  logic                   preset;

  assign fill   = wr_ptr - rd_ptr;
  assign preset = cfg_we && (cfg_index == REG_START_POS);

  // next state for one item
  always_comb begin
    position_next = position;
    tick_next     = tick;
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    dropped       = 1'b0;
    popped        = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = wr_ptr[ADDR_W-1:0];
    ram_req.wdata = position;
    ram_req.re    = 1'b0;
    ram_req.raddr = rd_ptr[ADDR_W-1:0];
    case (mode)
      MODE_EDGE: begin
        if (level_a != level_b) position_next = position + 1'b1;
        else                    position_next = position - 1'b1;
      end
      MODE_TICK: begin
        if (tick == sample_top) begin
          tick_next = '0;
          if (fill >= DEPTH_P) begin
            dropped = 1'b1;
          end else begin
            ram_req.we  = accept;
            wr_ptr_next = wr_ptr + 1'b1;
          end
        end else begin
          tick_next = tick + 1'b1;
        end
      end
      MODE_READ: begin
        if (fill != '0) begin
          popped      = 1'b1;
          ram_req.re  = accept;
          rd_ptr_next = rd_ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
    fill_next            = wr_ptr_next - rd_ptr_next;
    res.sample_valid     = popped;
    res.fifo_fill        = FILL_W'(fill_next);
    res.sample_dropped   = dropped;
    res.current_position = position_next;
  end

  // state update; configuration writes must only arrive while idle (kept by the user, unchecked here)
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= START_RESET;
      tick       <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      sample_top <= TOP_RESET;
    end else begin
      // writing start_position presets the counter
      if (preset) begin
        position <= COUNT_WIDTH'(cfg_data);
      end else if (accept) begin
        position <= position_next;
      end
      if (accept) begin
        tick   <= tick_next;
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
      end
      if (cfg_we && (cfg_index == REG_SAMPLE_TOP)) begin
        sample_top <= TICK_W'(cfg_data);
      end
    end
  end

endmodule

@@ hw/rtl/quadrature_position_sampler_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// quadrature_position_sampler_fifo_unit
// 2x quadrature position counter with timed snapshots into a sample FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: mode 0 is a channel A edge with the
//   A and B levels, mode 1 a timer tick, mode 2 a request for the oldest
//   snapshot; mode 3 changes nothing.
//   result returns one item per command: popped sample and its valid flag,
//   FIFO fill, drop flag and the position after the command.
//   The result is valid the cycle after the command is accepted. Throughput
//   is one item per cycle while result is not stalled; counters and pointers
//   update on accept and the snapshot store is read on its one read port at
//   accept time, its registered data driving the sample field.
//   When result is stalled, cmd.ready drops once the result register is
//   full, and both the result and the store read data hold until taken.
//   Reset (rst, synchronous) empties the FIFO, clears the tick counter,
//   sets sample_top to 9999 and the position to 32768.
//   cfg_we/cfg_index/cfg_data write the registers; the user must do so only
//   while idle, unchecked; writing start_position presets the position counter.
// ----------------------------------------------------------------------------
module quadrature_position_sampler_fifo_unit
  import qps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  qps_cmd_if.sink               cmd,
  qps_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                   accept;
  logic                   out_valid;
  ram_req_t               ram_req;
  result_t                res;
  result_t                res_q;
  logic [COUNT_WIDTH-1:0] rdata;

  assign cmd.ready = !out_valid || result.ready;
  assign accept    = cmd.valid && cmd.ready;

  qps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (cmd.mode),
    .level_a   (cmd.level_a),
    .level_b   (cmd.level_b),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .res       (res)
  );

  qps_sample_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.sample_value     = res_q.sample_valid ? rdata : '0;
  assign result.sample_valid     = res_q.sample_valid;
  assign result.fifo_fill        = res_q.fifo_fill;
  assign result.sample_dropped   = res_q.sample_dropped;
  assign result.current_position = res_q.current_position;

endmodule
